[rtl/lwkd_pkg.sv]
// ----------------------------------------------------------------------------
// lwkd_pkg
// Types and constants for the longest window with at most k distinct bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package lwkd_pkg;

  localparam int MAX_LEN = 4096;
  localparam int SYM_NUM = 256;
  localparam int SYM_W   = 8;
  localparam int HIST_AW = $clog2(MAX_LEN);
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int LEN_W   = 13;
  localparam int CNT_W   = POS_W;
  localparam int DIST_W  = 9;
  localparam int LIM_W   = 9;

  typedef struct packed {
    logic [SYM_W-1:0] ch;
    logic             first;
  } lwkd_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] best_len;
    logic [LEN_W-1:0] window_len;
    logic             overflow;
  } lwkd_out_t;

endpackage

`default_nettype wire

[rtl/longest_window_k_distinct_top.sv]
// ----------------------------------------------------------------------------
// longest_window_k_distinct_top
// Sliding window over a byte stream that tracks the longest window holding at
// most max_distinct distinct byte values.
//
// Input channel (in_valid/in_ready/in_data) takes one character per request,
// with a flag that opens a new string. Output channel (out_valid/out_ready/
// out_data) returns one result per request: best length, current window
// length and a sticky overflow flag.
// One request at a time: a character passes S_INC and S_CHK, plus S_HRD, S_DEC
// and S_CHK again for each character dropped from the left of the window,
// then S_OUT loads the output register; each character leaves the window
// once. The shrink loop reads the history memory, then the count memory, and
// writes the count back. A character beyond MAX_LEN goes straight to S_OUT
// and only sets overflow.
// Reset (rst, synchronous) clears pointers, counts and flags and sets
// max_distinct to 1; the history memory needs no clearing.
// A stalled receiver holds the result in the output register; the next
// request is taken meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_window_k_distinct_top
  import lwkd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [LIM_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lwkd_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lwkd_out_t             out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INC  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_HRD  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

  logic [2:0]         state;
  logic [LIM_W-1:0]   max_distinct;
  logic [POS_W-1:0]   left_pos;
  logic [POS_W-1:0]   right_pos;
  logic [DIST_W-1:0]  distinct_count;
  logic [POS_W-1:0]   best_so_far;
  logic               overflow_flag;
  logic [SYM_W-1:0]   ch_q;

  // count memory with per-entry valid bits
  logic [CNT_W-1:0]   cnt_mem [SYM_NUM];
  logic [SYM_NUM-1:0] cnt_vld;
  logic [CNT_W-1:0]   cnt_rdata;
  logic               cnt_rd_vld;
  logic [CNT_W-1:0]   cnt_val;
  logic               cnt_re;
  logic [SYM_W-1:0]   cnt_raddr;
  logic               cnt_we;
  logic [SYM_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;

  // history memory
  logic [SYM_W-1:0]   hist_mem [MAX_LEN];
  logic [SYM_W-1:0]   hist_q;
  logic               hist_we;
  logic               hist_re;

  logic               accept;
  logic               do_shrink;
  logic [POS_W-1:0]   win_len;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign win_len   = right_pos - left_pos;
  assign cnt_val   = cnt_rd_vld ? cnt_rdata : '0;
  assign do_shrink = (DIST_W'(distinct_count) > DIST_W'(max_distinct)) &&
                     (left_pos < right_pos);

  assign hist_we   = accept && (in_data.first || (right_pos < MAX_POS));
  assign hist_re   = (state == S_CHK) && do_shrink;

  always_comb begin
    cnt_re    = 1'b0;
    cnt_raddr = in_data.ch;
    cnt_we    = 1'b0;
    cnt_waddr = ch_q;
    cnt_wdata = cnt_val + CNT_W'(1);
    if (hist_we) begin
      cnt_re = 1'b1;
    end
    if (state == S_HRD) begin
      cnt_re    = 1'b1;
      cnt_raddr = hist_q;
    end
    if (state == S_INC) begin
      cnt_we = 1'b1;
    end
    if ((state == S_DEC) && (cnt_val != '0)) begin
      cnt_we    = 1'b1;
      cnt_waddr = hist_q;
      cnt_wdata = cnt_val - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld    <= '0;
      cnt_rd_vld <= 1'b0;
    end else begin
      if (accept && in_data.first) begin
        cnt_vld <= '0;
      end else if (cnt_we) begin
        cnt_vld[cnt_waddr] <= 1'b1;
      end
      if (cnt_re) begin
        cnt_rd_vld <= cnt_vld[cnt_raddr] && !(accept && in_data.first);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[(in_data.first ? HIST_AW'(0) : right_pos[HIST_AW-1:0])] <= in_data.ch;
    end
    if (hist_re) begin
      hist_q <= hist_mem[left_pos[HIST_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distinct <= LIM_W'(1);
    end else if (cfg_wen) begin
      max_distinct <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      left_pos       <= '0;
      right_pos      <= '0;
      distinct_count <= '0;
      best_so_far    <= '0;
      overflow_flag  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ch_q <= in_data.ch;
            if (in_data.first) begin
              left_pos       <= '0;
              right_pos      <= '0;
              distinct_count <= '0;
              best_so_far    <= '0;
              overflow_flag  <= 1'b0;
              state          <= S_INC;
            end else if (right_pos < MAX_POS) begin
              state <= S_INC;
            end else begin
              overflow_flag <= 1'b1;
              state         <= S_OUT;
            end
          end
        end
        S_INC: begin
          right_pos <= right_pos + POS_W'(1);
          if (cnt_val == '0) begin
            distinct_count <= distinct_count + DIST_W'(1);
          end
          state <= S_CHK;
        end
        S_CHK: begin
          if (do_shrink) begin
            state <= S_HRD;
          end else begin
            if (win_len > best_so_far) begin
              best_so_far <= win_len;
            end
            state <= S_OUT;
          end
        end
        S_HRD: begin
          state <= S_DEC;
        end
        S_DEC: begin
          if (cnt_val == CNT_W'(1)) begin
            distinct_count <= distinct_count - DIST_W'(1);
          end
          left_pos <= left_pos + POS_W'(1);
          state    <= S_CHK;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.best_len   <= LEN_W'(best_so_far);
            out_data.window_len <= LEN_W'(win_len);
            out_data.overflow   <= overflow_flag;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_left_le_right: assert property (@(posedge clk) disable iff (rst)
    left_pos <= right_pos)
    else $error("window start passed window end");

  a_right_bound: assert property (@(posedge clk) disable iff (rst)
    right_pos <= MAX_POS)
    else $error("string position beyond history capacity");

  a_distinct_bound: assert property (@(posedge clk) disable iff (rst)
    distinct_count <= DIST_W'(SYM_NUM))
    else $error("distinct count beyond alphabet size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken while previous one in flight");
`endif

endmodule

`default_nettype wire

[test/tb_longest_window_k_distinct_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_longest_window_k_distinct_top
// Drives byte strings into the longest-window block and checks every result
// against an in-bench sliding window tracker: count table, history, window
// pointers, best length and sticky overflow. Covers the limit extremes, the
// zero limit, long strings, random strings with random handshake gaps, and a
// long receiver hold that backs up the input.
// ----------------------------------------------------------------------------

module tb_longest_window_k_distinct_top;
  import lwkd_pkg::*;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wen;
  logic [LIM_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  lwkd_in_t         in_data;
  logic             out_valid;
  logic             out_ready;
  lwkd_out_t        out_data;

  longest_window_k_distinct_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // window tracker state
  int         limit_reg;
  int         char_counts [SYM_NUM];
  logic [7:0] history [MAX_LEN];
  int         left_pos;
  int         right_pos;
  int         distinct_count;
  int         best_len_so_far;
  logic       overflow_seen;

  lwkd_out_t  expected_windows [$];
  int         mismatch_count = 0;
  bit         src_idle_en = 1'b1;
  bit         sink_idle_en = 1'b1;
  int         hold_request = 0;

  function automatic void restart_string();
    foreach (char_counts[i]) char_counts[i] = 0;
    left_pos        = 0;
    right_pos       = 0;
    distinct_count  = 0;
    best_len_so_far = 0;
    overflow_seen   = 1'b0;
  endfunction

  function automatic lwkd_out_t advance_window(input lwkd_in_t req);
    lwkd_out_t  res;
    logic [7:0] dropped;
    if (req.first) restart_string();
    if (right_pos >= MAX_LEN) begin
      overflow_seen = 1'b1;
    end else begin
      history[right_pos] = req.ch;
      right_pos++;
      if (char_counts[req.ch] == 0) distinct_count++;
      char_counts[req.ch]++;
      while (distinct_count > limit_reg && left_pos < right_pos) begin
        dropped = history[left_pos];
        if (char_counts[dropped] > 0) begin
          char_counts[dropped]--;
          if (char_counts[dropped] == 0) distinct_count--;
        end
        left_pos++;
      end
      if (right_pos - left_pos > best_len_so_far) best_len_so_far = right_pos - left_pos;
    end
    res.best_len   = LEN_W'(best_len_so_far);
    res.window_len = LEN_W'(right_pos - left_pos);
    res.overflow   = overflow_seen;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int wanted);
    if (mismatch_count < 100)
      $display("%0t ns: mismatch on %s, got %0d, wanted %0d", $time, what, got, wanted);
    mismatch_count++;
  endtask

  // one character request, predicted when taken
  task automatic send_char(input logic [SYM_W-1:0] c, input logic f);
    lwkd_in_t req;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req.ch    = c;
    req.first = f;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_windows.push_back(advance_window(req));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(input int value);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_wdata <= LIM_W'(value);
    cfg_wen   <= 1'b1;
    limit_reg  = value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    lwkd_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_windows.size() == 0) begin
        report_mismatch("result with no request pending", out_data.window_len, -1);
      end else begin
        want = expected_windows.pop_front();
        if (out_data.best_len !== want.best_len)
          report_mismatch("best_len", out_data.best_len, want.best_len);
        if (out_data.window_len !== want.window_len)
          report_mismatch("window_len", out_data.window_len, want.window_len);
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    // continues the string left by reset, limit 1
    send_char(8'h61, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h00, 1'b0);
    set_limit(2);
    send_char(8'h61, 1'b1);
    send_char(8'h62, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h63, 1'b0);
    send_char(8'h63, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'hFF, 1'b1);
    // zero limit drops every character at once
    set_limit(0);
    send_char(8'h10, 1'b1);
    send_char(8'h10, 1'b0);
    send_char(8'h20, 1'b0);
    // limits above 256 never shrink
    set_limit(511);
    send_char(8'h01, 1'b1);
    send_char(8'h02, 1'b0);
    send_char(8'h03, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h01, 1'b0);
    set_limit(257);
    send_char(8'hAA, 1'b0);
    send_char(8'h55, 1'b1);
  endtask

  task automatic test_long_strings();
    // all 256 byte values in one string, then random bytes on top
    set_limit(256);
    for (int i = 0; i < SYM_NUM + 44; i++)
      send_char((i < SYM_NUM) ? 8'(i) : 8'($urandom), i == 0);
    send_char(8'hFF, 1'b1);
    // long string that keeps shrinking from the left
    set_limit(3);
    for (int i = 0; i < 300; i++)
      send_char(8'h7C + 8'($urandom_range(0, 4)), i == 0);
  endtask

  task automatic random_strings(input int count);
    int alpha;
    int run_len;
    int base;
    int sent;
    sent = 0;
    while (sent < count) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      alpha   = (limit_reg < 8) ? $urandom_range(1, limit_reg + 3) : $urandom_range(1, 40);
      base    = $urandom_range(0, 255);
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        else
          send_char(8'(base + $urandom_range(0, alpha - 1)),
                    i == 0 && (sent > 0 || $urandom_range(0, 1) == 1));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_limit(2);
        1:       set_limit($urandom_range(3, 12));
        2:       set_limit(1);
        3:       set_limit($urandom_range(0, 511));
        4:       set_limit(256);
        default: set_limit($urandom_range(13, 80));
      endcase
      random_strings(130);
    end
  endtask

  task automatic test_backpressure();
    set_limit(2);
    src_idle_en  = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 40; i++) send_char(8'($urandom_range(0, 3)), i == 0);
    src_idle_en  = 1'b1;
  endtask

  task automatic test_tail();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_limit($urandom_range(0, 4));
    random_strings(100);
  endtask

  initial begin
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    limit_reg = 1;
    restart_string();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_long_strings();
    test_random();
    test_backpressure();
    test_tail();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_windows.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
